// ----- hdl/assert_macros.svh -----
// assertion macros shared by the clipper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define LSWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define LSWC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hdl/lswc_pkg.sv -----
// types, constants and helpers for the segment window clipper
`timescale 1ns / 1ps
package lswc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int FIFO_DEPTH      = 4;
    localparam int NUM_EDGES       = 4;
    localparam int CFG_IDX_WIDTH   = 2;

    // difference width, parameter width, encoded compare width
    localparam int DW = COORD_WIDTH + 1;
    localparam int QW = PARAM_FRAC_BITS + 1;
    localparam int RW = PARAM_FRAC_BITS + 2;

    localparam logic [QW-1:0] T_ONE = QW'(1) << PARAM_FRAC_BITS;
    localparam logic [RW-1:0] R_ONE = RW'(1) << PARAM_FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOP    = 2'd3;

    // edge outcome known before the division
    typedef enum logic [2:0] {
        K_SKIP,
        K_REJECT,
        K_NEG,
        K_OVER,
        K_ONE,
        K_DIV
    } t_kind;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        t_kind         kind;
        logic          enter;
    } t_edge;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x0;
        logic signed [COORD_WIDTH-1:0] y0;
        logic signed [DW-1:0]          dx;
        logic signed [DW-1:0]          dy;
        t_edge [NUM_EDGES-1:0]         edges;
    } t_item;

    // classify one edge from its p and q
    function automatic t_edge classify(input logic signed [DW-1:0] p,
                                       input logic signed [DW-1:0] q);
        t_edge e;
        e.num   = q[DW-1] ? DW'(-q) : DW'(q);
        e.den   = p[DW-1] ? DW'(-p) : DW'(p);
        e.enter = p[DW-1];
        priority if (p == '0) begin
            e.kind = q[DW-1] ? K_REJECT : K_SKIP;
        end else if (q != '0 && q[DW-1] != p[DW-1]) begin
            e.kind = K_NEG;
        end else if (e.num > e.den) begin
            e.kind = K_OVER;
        end else if (e.num == e.den) begin
            e.kind = K_ONE;
        end else begin
            e.kind = K_DIV;
        end
        return e;
    endfunction

endpackage

// ----- hdl/line_segment_window_clip_core.sv -----
// top level of the parametric segment window clipper
//
//  channel  direction  handshake                  payload
//  cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//  in       in         i_in_valid / o_in_ready    i_start_x/y, i_end_x/y
//  out      out        o_out_valid / i_out_ready  o_visible, o_clip_start_x/y, o_clip_end_x/y
//
//  one segment per cycle sustained while no result is held; after transfer in a
//  segment passes the queue, the divider load and quotient stages, the decision,
//  product and result registers; synchronous active-low reset clears pointers
//  and valid bits and loads the default window
//  a held result stalls the whole back pipeline; the front keeps taking
//  segments until the queue of FIFO_DEPTH entries is full
`timescale 1ns / 1ps
module line_segment_window_clip_core #(
    parameter int FIFO_DEPTH = lswc_pkg::FIFO_DEPTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lswc_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0] i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0] i_start_x,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0] i_start_y,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0] i_end_x,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0] i_end_y,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_visible,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_start_x,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_start_y,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_end_x,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_end_y
);

    logic            full, empty, push, pop;
    lswc_pkg::t_item front_item, queue_item;

    // classification front end
    lswc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_full      (full),
        .o_push      (push),
        .o_item      (front_item)
    );

    // decoupling queue
    lswc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    // clipping back end
    lswc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_visible      (o_visible),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

endmodule

// ----- hdl/lswc_front.sv -----
// front end: window registers and edge classification of each segment
`timescale 1ns / 1ps
module lswc_front (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [lswc_pkg::CFG_IDX_WIDTH-1:0]           i_cfg_index,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0]      i_cfg_data,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0]      i_start_x,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0]      i_start_y,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0]      i_end_x,
    input  logic signed [lswc_pkg::COORD_WIDTH-1:0]      i_end_y,
    input  logic                                         i_full,
    output logic                                         o_push,
    output lswc_pkg::t_item                              o_item
);

    localparam int CW = lswc_pkg::COORD_WIDTH;
    localparam int DW = lswc_pkg::DW;

    logic signed [CW-1:0] r_left, r_right, r_bottom, r_top;
    logic signed [DW-1:0] x0, y0, x1, y1, dx, dy;
    logic signed [DW-1:0] left_e, right_e, bottom_e, top_e;

    // window registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= CW'(32767);
            r_bottom <= '0;
            r_top    <= CW'(32767);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lswc_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                lswc_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                lswc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                lswc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // segment differences, exact in one extra bit
    assign x0       = {i_start_x[CW-1], i_start_x};
    assign y0       = {i_start_y[CW-1], i_start_y};
    assign x1       = {i_end_x[CW-1], i_end_x};
    assign y1       = {i_end_y[CW-1], i_end_y};
    assign left_e   = {r_left[CW-1], r_left};
    assign right_e  = {r_right[CW-1], r_right};
    assign bottom_e = {r_bottom[CW-1], r_bottom};
    assign top_e    = {r_top[CW-1], r_top};
    assign dx       = x1 - x0;
    assign dy       = y1 - y0;

    // classify the edges, left right bottom top
    always_comb begin
        o_item.x0       = i_start_x;
        o_item.y0       = i_start_y;
        o_item.dx       = dx;
        o_item.dy       = dy;
        o_item.edges[0] = lswc_pkg::classify(-dx, x0 - left_e);
        o_item.edges[1] = lswc_pkg::classify(dx, right_e - x0);
        o_item.edges[2] = lswc_pkg::classify(-dy, y0 - bottom_e);
        o_item.edges[3] = lswc_pkg::classify(dy, top_e - y0);
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

// ----- hdl/lswc_fifo.sv -----
// short queue between the front end and the clipping pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lswc_fifo #(
    parameter int DEPTH = lswc_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lswc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lswc_pkg::t_item o_item
);

    localparam int AW = $clog2(DEPTH);

    lswc_pkg::t_item r_mem [DEPTH];
    logic [AW:0] r_wr, r_rd, n_wr, n_rd;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_item;
        end
    end

    // pointers
    assign n_wr = i_push ? r_wr + (AW+1)'(1) : r_wr;
    assign n_rd = i_pop  ? r_rd + (AW+1)'(1) : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_item  = r_mem[r_rd[AW-1:0]];

    `LSWC_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "queue push while full")
    `LSWC_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty, "queue pop while empty")
    `LSWC_ASSERT(a_fill_step, i_clk, i_rst_n, (i_push && !i_pop) |=> !o_empty, "push lost")

endmodule

// ----- hdl/lswc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, rounded result
`timescale 1ns / 1ps
module lswc_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [lswc_pkg::DW-1:0] i_num,
    input  logic [lswc_pkg::DW-1:0] i_den,
    output logic [lswc_pkg::QW-1:0] o_quo
);

    localparam int DW = lswc_pkg::DW;
    localparam int QW = lswc_pkg::QW;
    localparam int F  = lswc_pkg::PARAM_FRAC_BITS;

    logic [DW-1:0] r_rem [F+1];
    logic [DW-1:0] r_den [F+1];
    logic [F-1:0]  r_quo [F+1];

    // load stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // one trial subtraction per stage
    for (genvar s = 0; s < F; s++) begin : g_stage
        logic [DW:0] trial, dext, diff;
        assign trial = {r_rem[s], 1'b0};
        assign dext  = {1'b0, r_den[s]};
        assign diff  = trial - dext;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                if (trial >= dext) begin
                    r_rem[s+1] <= diff[DW-1:0];
                    r_quo[s+1] <= {r_quo[s][F-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= trial[DW-1:0];
                    r_quo[s+1] <= {r_quo[s][F-2:0], 1'b0};
                end
            end
        end
    end

    // round to nearest, ties up
    assign o_quo = ({r_rem[F], 1'b0} >= {1'b0, r_den[F]})
                   ? {1'b0, r_quo[F]} + QW'(1) : {1'b0, r_quo[F]};

endmodule

// ----- hdl/lswc_back.sv -----
// back end: edge divisions, parameter update, endpoint interpolation
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lswc_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_empty,
    input  lswc_pkg::t_item                         i_item,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic                                    o_visible,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_start_x,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_start_y,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_end_x,
    output logic signed [lswc_pkg::COORD_WIDTH-1:0] o_clip_end_y
);

    localparam int CW = lswc_pkg::COORD_WIDTH;
    localparam int DW = lswc_pkg::DW;
    localparam int QW = lswc_pkg::QW;
    localparam int RW = lswc_pkg::RW;
    localparam int F  = lswc_pkg::PARAM_FRAC_BITS;
    localparam int NE = lswc_pkg::NUM_EDGES;
    localparam int PW = DW + QW;
    localparam int LW = PW - F + 1;

    logic en;
    lswc_pkg::t_item r_pipe [F+1];
    logic [F:0]      r_vld;
    logic [QW-1:0]   quo [NE];

    // whole pipeline advances unless the result register is held
    assign en    = !o_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    // dividers, one per edge
    for (genvar e = 0; e < NE; e++) begin : g_div
        lswc_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (i_item.edges[e].num),
            .i_den (i_item.edges[e].den),
            .o_quo (quo[e])
        );
    end

    // item carried alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pipe[0] <= i_item;
            for (int s = 0; s < F; s++) begin
                r_pipe[s+1] <= r_pipe[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[F-1:0], o_pop};
        end
    end

    // parameter update over the edges in order
    logic          ok;
    logic [QW-1:0] t0, t1;

    always_comb begin
        logic [RW-1:0] renc;
        lswc_pkg::t_kind kind;
        ok = 1'b1;
        t0 = '0;
        t1 = lswc_pkg::T_ONE;
        for (int e = 0; e < NE; e++) begin
            kind = r_pipe[F].edges[e].kind;
            unique case (kind)
                lswc_pkg::K_OVER: renc = lswc_pkg::R_ONE + RW'(2);
                lswc_pkg::K_ONE:  renc = lswc_pkg::R_ONE + RW'(1);
                lswc_pkg::K_DIV:  renc = RW'(quo[e]) + RW'(1);
                default:          renc = '0;
            endcase
            if (kind == lswc_pkg::K_REJECT) begin
                ok = 1'b0;
            end else if (kind != lswc_pkg::K_SKIP) begin
                if (r_pipe[F].edges[e].enter) begin
                    if (renc > RW'(t1) + RW'(1)) begin
                        ok = 1'b0;
                    end else if (renc > RW'(t0) + RW'(1)) begin
                        t0 = QW'(renc - RW'(1));
                    end
                end else begin
                    if (renc < RW'(t0) + RW'(1)) begin
                        ok = 1'b0;
                    end else if (renc < RW'(t1) + RW'(1)) begin
                        t1 = QW'(renc - RW'(1));
                    end
                end
            end
        end
    end

    // decision stage
    logic                 r_d_vld, r_d_ok;
    logic [QW-1:0]        r_d_t0, r_d_t1;
    logic signed [CW-1:0] r_d_x0, r_d_y0;
    logic signed [DW-1:0] r_d_dx, r_d_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ok <= ok;
            r_d_t0 <= t0;
            r_d_t1 <= t1;
            r_d_x0 <= r_pipe[F].x0;
            r_d_y0 <= r_pipe[F].y0;
            r_d_dx <= r_pipe[F].dx;
            r_d_dy <= r_pipe[F].dy;
        end
    end

    // product stage, four magnitude times parameter products
    logic [DW-1:0]        mag_x, mag_y;
    logic                 r_m_vld, r_m_ok, r_m_nx, r_m_ny;
    logic [PW-1:0]        r_m_sx, r_m_sy, r_m_ex, r_m_ey;
    logic signed [CW-1:0] r_m_x0, r_m_y0;

    assign mag_x = r_d_dx[DW-1] ? DW'(-r_d_dx) : DW'(r_d_dx);
    assign mag_y = r_d_dy[DW-1] ? DW'(-r_d_dy) : DW'(r_d_dy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_ok <= r_d_ok;
            r_m_nx <= r_d_dx[DW-1];
            r_m_ny <= r_d_dy[DW-1];
            r_m_sx <= PW'(mag_x) * PW'(r_d_t0);
            r_m_sy <= PW'(mag_y) * PW'(r_d_t0);
            r_m_ex <= PW'(mag_x) * PW'(r_d_t1);
            r_m_ey <= PW'(mag_y) * PW'(r_d_t1);
            r_m_x0 <= r_d_x0;
            r_m_y0 <= r_d_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld     <= 1'b0;
            r_m_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_d_vld     <= r_vld[F];
            r_m_vld     <= r_d_vld;
            o_out_valid <= r_m_vld;
        end
    end

    // round magnitude to nearest, ties away from zero, then offset
    function automatic logic [CW-1:0] lerp_out(input logic signed [CW-1:0] a,
                                               input logic [PW-1:0] prod,
                                               input logic neg);
        logic [PW-1:0]        rnd;
        logic signed [LW-1:0] ae, re, sum;
        rnd = (prod + (PW'(1) << (F - 1))) >> F;
        ae  = LW'(a);
        re  = $signed({1'b0, rnd[PW-F-1:0]});
        sum = neg ? ae - re : ae + re;
        return sum[CW-1:0];
    endfunction

    // result register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_visible      <= r_m_ok;
            o_clip_start_x <= r_m_ok ? lerp_out(r_m_x0, r_m_sx, r_m_nx) : '0;
            o_clip_start_y <= r_m_ok ? lerp_out(r_m_y0, r_m_sy, r_m_ny) : '0;
            o_clip_end_x   <= r_m_ok ? lerp_out(r_m_x0, r_m_ex, r_m_nx) : '0;
            o_clip_end_y   <= r_m_ok ? lerp_out(r_m_y0, r_m_ey, r_m_ny) : '0;
        end
    end

    `LSWC_ASSERT(a_reject_zero, i_clk, i_rst_n, (o_out_valid && !o_visible) |-> (o_clip_start_x == '0 && o_clip_start_y == '0 && o_clip_end_x == '0 && o_clip_end_y == '0), "rejected segment with nonzero endpoints")
    `LSWC_ASSERT(a_stall_keeps, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_m_vld)), "pipeline moved during stall")
    `LSWC_ASSERT_ALWAYS(a_no_pop_stall, i_clk, (o_out_valid && !i_out_ready) |-> !o_pop, "queue popped during stall")

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for the segment window clipper
`timescale 1ns / 1ps
module tb;

    localparam int CW        = lswc_pkg::COORD_WIDTH;
    localparam int FB        = lswc_pkg::PARAM_FRAC_BITS;
    localparam int IW        = lswc_pkg::CFG_IDX_WIDTH;
    localparam int LATENCY   = lswc_pkg::PARAM_FRAC_BITS + 4;
    localparam int WDOG_MAX  = 4000;

    typedef struct {
        logic                 vis;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } t_clip;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IW-1:0]        i_cfg_index = '0;
    logic signed [CW-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_visible;
    logic signed [CW-1:0] o_clip_start_x, o_clip_start_y, o_clip_end_x, o_clip_end_y;

    line_segment_window_clip_core dut (.*);

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the window
    longint win_left = 0, win_right = 32767, win_bottom = 0, win_top = 32767;

    t_clip  clip_queue[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     recv_hold = 1'b0;
    int     results_seen = 0;
    int     rejects_seen = 0;
    int     idle_cycles = 0;

    // rounded edge parameter in Q1.16; -1 below zero, ONE+1 above one
    function automatic longint edge_param(longint q, longint p);
        longint n, d, rem, quo;
        n = (q < 0) ? -q : q;
        d = (p < 0) ? -p : p;
        quo = 0;
        if (q != 0 && ((q < 0) != (p < 0))) return -1;
        if (n > d) return (longint'(1) << FB) + 1;
        if (n == d) return longint'(1) << FB;
        rem = n;
        for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= d) begin
                rem -= d;
                quo |= 1;
            end
        end
        if ((rem << 1) >= d) quo++;
        return quo;
    endfunction

    // a + round(t * d), ties away from zero
    function automatic logic signed [CW-1:0] interp(longint a, longint d, longint t);
        longint m, r;
        m = (d < 0) ? -d : d;
        r = (m * t + (longint'(1) << (FB - 1))) >>> FB;
        return CW'((d < 0) ? a - r : a + r);
    endfunction

    function automatic t_clip clip_segment(longint x0, longint y0, longint x1, longint y1);
        t_clip  c;
        longint dx, dy, t0, t1, p, q, r;
        bit     ok;
        dx = x1 - x0;
        dy = y1 - y0;
        t0 = 0;
        t1 = longint'(1) << FB;
        ok = 1'b1;
        p = 0;
        q = 0;
        for (int e = 0; e < lswc_pkg::NUM_EDGES && ok; e++) begin
            case (e)
                0: begin p = -dx; q = x0 - win_left; end
                1: begin p = dx;  q = win_right - x0; end
                2: begin p = -dy; q = y0 - win_bottom; end
                default: begin p = dy; q = win_top - y0; end
            endcase
            if (p == 0) begin
                if (q < 0) ok = 1'b0;
            end else begin
                r = edge_param(q, p);
                if (p < 0) begin
                    if (r > t1) ok = 1'b0;
                    else if (r > t0) t0 = r;
                end else begin
                    if (r < t0) ok = 1'b0;
                    else if (r < t1) t1 = r;
                end
            end
        end
        c = '{1'b0, '0, '0, '0, '0};
        if (ok) begin
            c.vis = 1'b1;
            c.sx = interp(x0, dx, t0);
            c.sy = interp(y0, dy, t0);
            c.ex = interp(x0, dx, t1);
            c.ey = interp(y0, dy, t1);
        end
        return c;
    endfunction

    // one segment transfer; valid stays up for a following segment
    task automatic send_segment(int sx, int sy, int ex, int ey);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= CW'(sx);
        i_start_y <= CW'(sy);
        i_end_x <= CW'(ex);
        i_end_y <= CW'(ey);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        clip_queue.push_back(clip_segment(longint'(sx), longint'(sy),
                                          longint'(ex), longint'(ey)));
    endtask

    // drop valid after the last segment of a series
    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(5))
            0: return int'($signed(CW'($urandom)));
            1: return -int'($urandom_range(40));
            2: return int'($urandom_range(40));
            3: return $urandom_range(1) ? 32767 : -32768;
            default: return int'($urandom_range(2000)) - 500;
        endcase
    endfunction

    task automatic wait_drain();
        stop_input();
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one register write, block idle; valid stays up for a following write
    task automatic write_window(logic [IW-1:0] idx, logic signed [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            lswc_pkg::CFG_LEFT:   win_left = val;
            lswc_pkg::CFG_RIGHT:  win_right = val;
            lswc_pkg::CFG_BOTTOM: win_bottom = val;
            default:              win_top = val;
        endcase
    endtask

    task automatic set_window(int l, int r, int b, int t);
        wait_drain();
        write_window(lswc_pkg::CFG_LEFT, CW'(l));
        write_window(lswc_pkg::CFG_RIGHT, CW'(r));
        write_window(lswc_pkg::CFG_BOTTOM, CW'(b));
        write_window(lswc_pkg::CFG_TOP, CW'(t));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_edge();
        return int'($signed(CW'($urandom)));
    endfunction

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_clip exp_c;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (clip_queue.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                exp_c = clip_queue.pop_front();
                if (!exp_c.vis) rejects_seen++;
                if (o_visible !== exp_c.vis) begin
                    $error("visible exp %0d got %0d", exp_c.vis, o_visible);
                    fail_count++;
                end
                if (o_clip_start_x !== exp_c.sx) begin
                    $error("clip_start_x exp %0d got %0d", exp_c.sx, o_clip_start_x);
                    fail_count++;
                end
                if (o_clip_start_y !== exp_c.sy) begin
                    $error("clip_start_y exp %0d got %0d", exp_c.sy, o_clip_start_y);
                    fail_count++;
                end
                if (o_clip_end_x !== exp_c.ex) begin
                    $error("clip_end_x exp %0d got %0d", exp_c.ex, o_clip_end_x);
                    fail_count++;
                end
                if (o_clip_end_y !== exp_c.ey) begin
                    $error("clip_end_y exp %0d got %0d", exp_c.ey, o_clip_end_y);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("line_segment_window_clip_core test failed");
            $finish;
        end
    end

    task automatic test_directed();
        set_window(-100, 100, -50, 50);
        send_segment(-200, 0, 200, 0);
        send_segment(0, -200, 0, 200);
        send_segment(-200, 60, 200, 60);
        send_segment(-200, 30, 200, 30);
        send_segment(-150, 0, -120, 10);
        send_segment(150, 0, 120, 10);
        send_segment(10, 10, 20, 20);
        send_segment(-101, -51, 101, 51);
        send_segment(-200, -200, 200, 200);
        send_segment(0, 0, 0, 0);
        send_segment(500, 0, 500, 0);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-300, 1, 301, 2);
        send_segment(-100, -50, 100, 50);
        send_segment(200, 200, -200, -199);
        send_segment(-7, 3, 7, -3);
        send_segment(33, 50, 34, 53);
        // inverted window
        set_window(100, -100, -50, 50);
        send_segment(-200, 0, 200, 0);
        send_segment(0, 0, 0, 0);
        // extremes of the window
        set_window(-32768, 32767, -32768, 32767);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(1, 2, 3, 4);
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_random();
        set_window(-500, 700, -300, 900);
        test_random_phase(90, 0, 0);
        test_random_phase(90, 51, 0);
        set_window(-20, 20, -32768, 32767);
        test_random_phase(90, 0, 51);
        test_random_phase(90, 22, 22);
        set_window(32767, 32767, -32768, -32768);
        test_random_phase(40, 0, 0);
        set_window(rand_edge(), rand_edge(), rand_edge(), rand_edge());
        test_random_phase(60, 22, 22);
        set_window(0, 32767, 0, 32767);
        test_random_phase(60, 0, 0);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                repeat (30) send_segment(rand_coord(), rand_coord(), rand_coord(),
                                         rand_coord());
                stop_input();
            end
        join
        // sender pauses until all results are back
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (10) send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        recv_stall_pct = 0;
        wait_drain();
        $display("covered %0d clipped segments, %0d rejected, across 8 window settings",
                 results_seen, rejects_seen);
        $display("idle and stall phases plus a long output hold-off");
        if (fail_count == 0 && clip_queue.size() == 0)
            $display("line_segment_window_clip_core test passed");
        else
            $display("line_segment_window_clip_core test failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/lswc_pkg.sv
hdl/lswc_front.sv
hdl/lswc_fifo.sv
hdl/lswc_div.sv
hdl/lswc_back.sv
hdl/line_segment_window_clip_core.sv
sim/tb.sv
